// File: sv/rth_pkg.sv
package rth_pkg;

   // channel and fraction formats of the pixel fields
   localparam int CHANNEL_BITS  = 8;
   localparam int FRACTION_BITS = 16;

   localparam int SUM_BITS = CHANNEL_BITS + 1;
   // hue numerator and 6*delta need three more bits than a channel
   localparam int NUM_BITS = CHANNEL_BITS + 3;

   localparam logic [SUM_BITS-1:0] CH_MAX     = SUM_BITS'((1 << CHANNEL_BITS) - 1);
   localparam logic [SUM_BITS-1:0] TWO_CH_MAX = SUM_BITS'(2 * ((1 << CHANNEL_BITS) - 1));

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] hue;
      logic [FRACTION_BITS-1:0] saturation;
      logic [SUM_BITS-1:0]      lightness_sum;
   } rsp_type;

   // state carried from cell to cell along the divider chain
   typedef struct packed {
      logic                     valid;
      logic                     gray;
      logic [SUM_BITS-1:0]      sum;
      logic [NUM_BITS-1:0]      hue_rem;
      logic [NUM_BITS-1:0]      hue_div;
      logic [FRACTION_BITS-1:0] hue_quo;
      logic [CHANNEL_BITS-1:0]  sat_rem;
      logic [CHANNEL_BITS-1:0]  sat_div;
      logic [FRACTION_BITS-1:0] sat_bits;
      logic [FRACTION_BITS-1:0] sat_quo;
   } stage_type;

endpackage

// File: sv/rth_front.sv
module rth_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  rth_pkg::req_type   in_data,
   output rth_pkg::stage_type out_ff
);

   localparam int CB = rth_pkg::CHANNEL_BITS;
   localparam int FB = rth_pkg::FRACTION_BITS;
   localparam int NB = rth_pkg::NUM_BITS;
   localparam int SB = rth_pkg::SUM_BITS;

   logic [CB-1:0]    hi, lo, delta;
   logic [SB-1:0]    sum;
   logic [CB-1:0]    den;
   logic [NB-1:0]    d_ext, r_ext, g_ext, b_ext, six_delta, num;
   logic [CB+FB-1:0] sat_n;
   rth_pkg::stage_type out_in;

   always_comb begin
      hi = in_data.red;
      lo = in_data.red;
      if (in_data.green > hi) hi = in_data.green;
      if (in_data.blue > hi)  hi = in_data.blue;
      if (in_data.green < lo) lo = in_data.green;
      if (in_data.blue < lo)  lo = in_data.blue;
      delta = hi - lo;
      sum   = {1'b0, hi} + {1'b0, lo};

      if (sum < rth_pkg::CH_MAX) begin
         den = sum[CB-1:0];
      end else begin
         den = CB'(rth_pkg::TWO_CH_MAX - sum);
      end

      d_ext     = NB'(delta);
      r_ext     = NB'(in_data.red);
      g_ext     = NB'(in_data.green);
      b_ext     = NB'(in_data.blue);
      six_delta = (d_ext << 2) + (d_ext << 1);

      // sector numerator, ties go to red then green
      if (in_data.red == hi) begin
         if (in_data.green >= in_data.blue) begin
            num = g_ext - b_ext;
         end else begin
            num = six_delta - (b_ext - g_ext);
         end
      end else if (in_data.green == hi) begin
         num = (d_ext << 1) + b_ext - r_ext;
      end else begin
         num = (d_ext << 2) + r_ext - g_ext;
      end

      // (2^FB - 1) * delta, upper part is the first partial remainder
      sat_n = {delta, {FB{1'b0}}} - {{FB{1'b0}}, delta};

      out_in.valid    = in_valid;
      out_in.gray     = (delta == '0);
      out_in.sum      = sum;
      out_in.hue_rem  = num;
      out_in.hue_div  = six_delta;
      out_in.hue_quo  = '0;
      out_in.sat_rem  = sat_n[CB+FB-1:FB];
      out_in.sat_div  = den;
      out_in.sat_bits = sat_n[FB-1:0];
      out_in.sat_quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff.valid <= out_in.valid;
      end
      if (enable) begin
         out_ff.gray     <= out_in.gray;
         out_ff.sum      <= out_in.sum;
         out_ff.hue_rem  <= out_in.hue_rem;
         out_ff.hue_div  <= out_in.hue_div;
         out_ff.hue_quo  <= out_in.hue_quo;
         out_ff.sat_rem  <= out_in.sat_rem;
         out_ff.sat_div  <= out_in.sat_div;
         out_ff.sat_bits <= out_in.sat_bits;
         out_ff.sat_quo  <= out_in.sat_quo;
      end
   end

endmodule

// File: sv/rth_cell.sv
module rth_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  rth_pkg::stage_type in_stage,
   output rth_pkg::stage_type out_ff
);

   localparam int CB = rth_pkg::CHANNEL_BITS;
   localparam int FB = rth_pkg::FRACTION_BITS;
   localparam int NB = rth_pkg::NUM_BITS;

   logic [NB:0] hue_sh, hue_diff;
   logic [CB:0] sat_sh, sat_diff;
   logic        hue_hit, sat_hit;
   rth_pkg::stage_type out_in;

   // one restoring step for each of the two quotients
   always_comb begin
      hue_sh   = {in_stage.hue_rem, 1'b0};
      hue_diff = hue_sh - {1'b0, in_stage.hue_div};
      hue_hit  = (hue_sh >= {1'b0, in_stage.hue_div});

      sat_sh   = {in_stage.sat_rem, in_stage.sat_bits[FB-1]};
      sat_diff = sat_sh - {1'b0, in_stage.sat_div};
      sat_hit  = (sat_sh >= {1'b0, in_stage.sat_div});

      out_in          = in_stage;
      out_in.hue_rem  = hue_hit ? hue_diff[NB-1:0] : hue_sh[NB-1:0];
      out_in.hue_quo  = {in_stage.hue_quo[FB-2:0], hue_hit};
      out_in.sat_rem  = sat_hit ? sat_diff[CB-1:0] : sat_sh[CB-1:0];
      out_in.sat_bits = {in_stage.sat_bits[FB-2:0], 1'b0};
      out_in.sat_quo  = {in_stage.sat_quo[FB-2:0], sat_hit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff.valid <= out_in.valid;
      end
      if (enable) begin
         out_ff.gray     <= out_in.gray;
         out_ff.sum      <= out_in.sum;
         out_ff.hue_rem  <= out_in.hue_rem;
         out_ff.hue_div  <= out_in.hue_div;
         out_ff.hue_quo  <= out_in.hue_quo;
         out_ff.sat_rem  <= out_in.sat_rem;
         out_ff.sat_div  <= out_in.sat_div;
         out_ff.sat_bits <= out_in.sat_bits;
         out_ff.sat_quo  <= out_in.sat_quo;
      end
   end

endmodule

// File: sv/rth_obuf.sv
module rth_obuf (
   input  logic             clock,
   input  logic             reset,
   output logic             space,
   input  logic             push_valid,
   input  rth_pkg::rsp_type push_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rth_pkg::rsp_type rsp_data
);

   localparam int          DEPTH = 2;
   localparam logic [1:0]  FULL  = 2'(DEPTH);

   rth_pkg::rsp_type mem_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign space     = (count_ff != FULL);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign push      = push_valid && space;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/rgb_to_hsl_top.sv
// rgb to hsl pixel converter
//
// req channel: one transaction carries one pixel (red, green, blue), each an
// unsigned 8-bit value v standing for v/255. rsp channel: one transaction per
// pixel, in order, carrying hue (fraction of a turn, /65536), saturation
// (/65535) and lightness_sum (max+min, lightness = value/510). both channels
// use valid/ready; a transaction happens when both are high at a clock edge.
//
// path: a req transaction passes one front stage that finds max, min, sector
// numerator and denominator, then a chain of 16 divider cells, each resolving
// one bit of hue and one bit of saturation, then the output buffer that
// drives rsp_valid. throughput: one pixel per cycle while the output buffer
// has space; the cell chain takes a new pixel every clock unless frozen.
//
// reset (synchronous, active high) empties the chain and the output buffer.
// stall: a two-entry output buffer sits after the chain; while it holds a
// single unread result the chain keeps moving and req_ready stays high. only
// when both entries wait does the whole chain freeze and req_ready drop.
// req_ready depends on registered state only.
module rgb_to_hsl_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rth_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rth_pkg::rsp_type rsp_data
);

   localparam int FB = rth_pkg::FRACTION_BITS;

   rth_pkg::stage_type chain [FB+1];
   rth_pkg::rsp_type   result;
   logic               advance;

   // front stage: extremes, numerators, divisors
   rth_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_ff   (chain[0])
   );

   // one quotient bit per cell for both divisions
   genvar i;
   generate
      for (i = 0; i < FB; i++) begin : g_cell
         rth_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .enable   (advance),
            .in_stage (chain[i]),
            .out_ff   (chain[i+1])
         );
      end
   endgenerate

   // gray pixels have no hue or saturation
   always_comb begin
      result.hue           = chain[FB].gray ? '0 : chain[FB].hue_quo;
      result.saturation    = chain[FB].gray ? '0 : chain[FB].sat_quo;
      result.lightness_sum = chain[FB].sum;
   end

   rth_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .space      (advance),
      .push_valid (chain[FB].valid),
      .push_data  (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign req_ready = advance;

`ifndef NO_ASSERTIONS
   // partial remainders stay below their divisors for colored pixels
   a_front_rem: assert property (@(posedge clock) disable iff (reset)
      chain[0].valid && !chain[0].gray |->
         chain[0].hue_rem < chain[0].hue_div && chain[0].sat_rem < chain[0].sat_div)
      else $error("front stage remainder not below divisor");

   a_last_rem: assert property (@(posedge clock) disable iff (reset)
      chain[FB].valid && !chain[FB].gray |->
         chain[FB].hue_rem < chain[FB].hue_div && chain[FB].sat_rem < chain[FB].sat_div)
      else $error("last cell remainder not below divisor");

   // a frozen chain keeps its last stage
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain[FB]))
      else $error("chain moved while output buffer full");

   // accepted pixel shows up at the head of the chain
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> chain[0].valid)
      else $error("accepted pixel lost at front stage");
`endif

endmodule
